### src/bdda_pkg.sv
// ----------------------------------------------------------------------------
// bdda_pkg
// Shared types, constants and calendar helpers for the business-day adder.
// ----------------------------------------------------------------------------
package bdda_pkg;

  localparam int YEAR_W    = 14;
  localparam int MONTH_W   = 4;
  localparam int DAY_W     = 5;
  localparam int WDAY_W    = 3;
  localparam int VACDAYS_W = 12;

  localparam logic [WDAY_W-1:0]  SUNDAY   = 3'd0;
  localparam logic [WDAY_W-1:0]  SATURDAY = 3'd6;
  localparam logic [MONTH_W-1:0] JANUARY  = 4'd1;
  localparam logic [MONTH_W-1:0] FEBRUARY = 4'd2;
  localparam logic [MONTH_W-1:0] DECEMBER = 4'd12;

  // floor(x / 100) = (x * 5243) >> 19 for x below 2^15
  localparam logic [12:0] RECIP_100       = 13'd5243;
  localparam int          RECIP_100_SHIFT = 19;
  // floor(x / 7) = (x * 37450) >> 18 for x below 21846
  localparam logic [15:0] RECIP_7         = 16'd37450;
  localparam int          RECIP_7_SHIFT   = 18;

  localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [WDAY_W-1:0]  wday;
  } date_t;

  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    logic [26:0]       p;
    logic [7:0]        q;
    logic [YEAR_W-1:0] r;
    p = 27'(y) * 27'(RECIP_100);
    q = p[26:RECIP_100_SHIFT];
    r = y - YEAR_W'(q) * YEAR_W'(100);
    return ((y[1:0] == 2'd0) && (r != '0)) || ((r == '0) && (q[1:0] == 2'd0));
  endfunction

  function automatic logic [DAY_W-1:0] days_in(input logic [YEAR_W-1:0] y,
                                               input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    if (m < JANUARY || m > DECEMBER) begin
      len = '0;
    end else if (m == FEBRUARY) begin
      len = is_leap(y) ? 5'd29 : 5'd28;
    end else begin
      len = MONTH_LEN[m - JANUARY];
    end
    return len;
  endfunction

  // floor(31 * mm / 12) for the shifted month 1..12
  function automatic logic [DAY_W-1:0] month_offset(input logic [MONTH_W-1:0] mm);
    logic [DAY_W-1:0] v;
    case (mm)
      4'd1:    v = 5'd2;
      4'd2:    v = 5'd5;
      4'd3:    v = 5'd7;
      4'd4:    v = 5'd10;
      4'd5:    v = 5'd12;
      4'd6:    v = 5'd15;
      4'd7:    v = 5'd18;
      4'd8:    v = 5'd20;
      4'd9:    v = 5'd23;
      4'd10:   v = 5'd25;
      4'd11:   v = 5'd28;
      4'd12:   v = 5'd31;
      default: v = 5'd0;
    endcase
    return v;
  endfunction

endpackage

### src/bdda_in_if.sv
// ----------------------------------------------------------------------------
// bdda_in_if
// Request channel: start date and business-day count.
// ----------------------------------------------------------------------------
interface bdda_in_if import bdda_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [YEAR_W-1:0]    start_year;
  logic [MONTH_W-1:0]   start_month;
  logic [DAY_W-1:0]     start_day;
  logic [VACDAYS_W-1:0] vacation_days;

  modport source (output valid, start_year, start_month, start_day, vacation_days,
                  input ready);
  modport sink (input valid, start_year, start_month, start_day, vacation_days,
                output ready);
endinterface

### src/bdda_out_if.sv
// ----------------------------------------------------------------------------
// bdda_out_if
// Result channel: return date, weekday and invalid flag.
// ----------------------------------------------------------------------------
interface bdda_out_if import bdda_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [YEAR_W-1:0]  return_year;
  logic [MONTH_W-1:0] return_month;
  logic [DAY_W-1:0]   return_day;
  logic [WDAY_W-1:0]  return_weekday;
  logic               date_invalid;

  modport source (output valid, return_year, return_month, return_day,
                  return_weekday, date_invalid, input ready);
  modport sink (input valid, return_year, return_month, return_day,
                return_weekday, date_invalid, output ready);
endinterface

### src/bdda_step.sv
// ----------------------------------------------------------------------------
// bdda_step
// Calendar step unit: next date and weekday, month length, weekend flag.
// ----------------------------------------------------------------------------
module bdda_step import bdda_pkg::*; (
  input  date_t            cur,
  output date_t            nxt,
  output logic [DAY_W-1:0] dim,
  output logic             weekend
);

  assign dim     = days_in(cur.year, cur.month);
  assign weekend = (cur.wday == SUNDAY) || (cur.wday == SATURDAY);

  always_comb begin
    nxt = cur;
    if (cur.day >= dim) begin
      nxt.day = 5'd1;
      if (cur.month >= DECEMBER) begin
        nxt.month = JANUARY;
        nxt.year  = cur.year + YEAR_W'(1);
      end else begin
        nxt.month = cur.month + MONTH_W'(1);
      end
    end else begin
      nxt.day = cur.day + DAY_W'(1);
    end
    nxt.wday = (cur.wday == SATURDAY) ? SUNDAY : cur.wday + WDAY_W'(1);
  end

endmodule

### src/bdda_weekday.sv
// ----------------------------------------------------------------------------
// bdda_weekday
// Multi-cycle weekday of a date, one shared reciprocal multiplier.
// ----------------------------------------------------------------------------
module bdda_weekday import bdda_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  date_t              date,
  output logic               done,
  output logic [WDAY_W-1:0]  wday
);

  localparam logic [2:0] W_IDLE = 3'd0;
  localparam logic [2:0] W_MUL1 = 3'd1;
  localparam logic [2:0] W_SUM  = 3'd2;
  localparam logic [2:0] W_MUL2 = 3'd3;
  localparam logic [2:0] W_REM  = 3'd4;

  logic [2:0]         state;
  logic [14:0]        yy;
  logic [MONTH_W-1:0] mm;
  logic [DAY_W-1:0]   dd;
  logic [14:0]        sum;
  logic [30:0]        prod;
  logic [14:0]        mul_a;
  logic [15:0]        mul_b;
  logic [7:0]         q100;
  logic [11:0]        q7;
  logic               early;

  assign early = (date.month <= FEBRUARY);
  assign q100  = prod[26:RECIP_100_SHIFT];
  assign q7    = prod[29:RECIP_7_SHIFT];

  // shared multiplier operands
  always_comb begin
    if (state == W_MUL1) begin
      mul_a = yy;
      mul_b = 16'(RECIP_100);
    end else begin
      mul_a = sum;
      mul_b = RECIP_7;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= W_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == W_REM);
      case (state)
        W_IDLE: begin
          if (start) begin
            yy    <= 15'(date.year) + 15'd400 - 15'(early);
            mm    <= early ? date.month + MONTH_W'(10) : date.month - MONTH_W'(2);
            dd    <= date.day;
            state <= W_MUL1;
          end
        end
        W_MUL1: begin
          prod  <= 31'(mul_a) * 31'(mul_b);
          state <= W_SUM;
        end
        W_SUM: begin
          sum   <= 15'(dd) + yy + (yy >> 2) - 15'(q100) + 15'(q100 >> 2)
                   + 15'(month_offset(mm));
          state <= W_MUL2;
        end
        W_MUL2: begin
          prod  <= 31'(mul_a) * 31'(mul_b);
          state <= W_REM;
        end
        W_REM: begin
          wday  <= WDAY_W'(sum - {q7, 3'b000} + 15'(q7));
          state <= W_IDLE;
        end
        default: state <= W_IDLE;
      endcase
    end
  end

endmodule

### src/business_day_date_adder_core.sv
// ----------------------------------------------------------------------------
// business_day_date_adder_core
// Adds a count of business days to a Gregorian date, one calendar day a cycle.
// ----------------------------------------------------------------------------
// One request is handled at a time and the request side is not ready meanwhile.
// A valid date passes a range check, then a four-step weekday calculation on
// one shared multiplier, then the step unit walks one calendar day per cycle,
// and a last step loads the output register. The number of calendar days walked
// is roughly 1.4 times the business-day count plus up to two weekend days at
// each end; the full count of 4095 walks about 5730 days. An invalid date goes
// from the range check straight to the last step. The result sits in an output
// register, so a new request is taken while the previous result still waits to
// be read; that request then holds in its last step until the result is read.
module business_day_date_adder_core import bdda_pkg::*; #(
  parameter int DAY_COUNT_WIDTH = 12
) (
  input  logic        clk,
  input  logic        rst,
  bdda_in_if.sink     din,
  bdda_out_if.source  dout
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_WDAY  = 3'd2;
  localparam logic [2:0] S_RUN   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]                 state;
  date_t                      cur;
  date_t                      nxt;
  logic [DAY_W-1:0]           dim;
  logic                       weekend;
  logic [DAY_COUNT_WIDTH-1:0] rem;
  logic                       invalid;
  logic                       chk_bad;
  logic                       wd_start;
  logic                       wd_done;
  logic [WDAY_W-1:0]          wd_val;

  bdda_step u_step (
    .cur     (cur),
    .nxt     (nxt),
    .dim     (dim),
    .weekend (weekend)
  );

  bdda_weekday u_weekday (
    .clk   (clk),
    .rst   (rst),
    .start (wd_start),
    .date  (cur),
    .done  (wd_done),
    .wday  (wd_val)
  );

  assign din.ready = (state == S_IDLE);
  assign chk_bad   = (cur.month < JANUARY) || (cur.month > DECEMBER) ||
                     (cur.day == '0) || (cur.day > dim);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      wd_start   <= 1'b0;
      dout.valid <= 1'b0;
    end else begin
      wd_start <= (state == S_CHECK) && !chk_bad;
      if (dout.ready && (state != S_DONE)) begin
        dout.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (din.valid) begin
            cur.year  <= din.start_year;
            cur.month <= din.start_month;
            cur.day   <= din.start_day;
            cur.wday  <= SUNDAY;
            rem       <= DAY_COUNT_WIDTH'(din.vacation_days);
            state     <= S_CHECK;
          end
        end
        S_CHECK: begin
          invalid <= chk_bad;
          if (chk_bad) begin
            state <= S_DONE;
          end else begin
            state <= S_WDAY;
          end
        end
        S_WDAY: begin
          if (wd_done) begin
            cur.wday <= wd_val;
            state    <= S_RUN;
          end
        end
        S_RUN: begin
          if (weekend) begin
            cur <= nxt;
          end else if (rem != '0) begin
            rem <= rem - DAY_COUNT_WIDTH'(1);
            cur <= nxt;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!dout.valid || dout.ready) begin
            dout.return_year    <= cur.year;
            dout.return_month   <= cur.month;
            dout.return_day     <= cur.day;
            dout.return_weekday <= cur.wday;
            dout.date_invalid   <= invalid;
            dout.valid          <= 1'b1;
            state               <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_to_check: assert property (@(posedge clk) disable iff (rst)
    din.valid && din.ready |=> state == S_CHECK)
    else $error("accepted item did not start the range check");

  a_wday_done_when_waiting: assert property (@(posedge clk) disable iff (rst)
    wd_done |-> state == S_WDAY)
    else $error("weekday unit finished outside its wait state");

  a_result_on_weekday: assert property (@(posedge clk) disable iff (rst)
    dout.valid && !dout.date_invalid |->
      dout.return_weekday != SUNDAY && dout.return_weekday != SATURDAY)
    else $error("valid result lands on a weekend");

  a_invalid_weekday_zero: assert property (@(posedge clk) disable iff (rst)
    dout.valid && dout.date_invalid |-> dout.return_weekday == SUNDAY)
    else $error("invalid result carries a weekday");

  a_run_wday_range: assert property (@(posedge clk) disable iff (rst)
    state == S_RUN |-> cur.wday <= SATURDAY)
    else $error("tracked weekday out of range");
`endif

endmodule

### sim/business_day_date_adder_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// business_day_date_adder_core_tb
// Sends start dates and business-day counts through the request channel. A
// calendar model inside the bench predicts each return date, its weekday and
// the invalid flag, and every item read from the result channel is checked
// against it in order. Corner dates come first, then random dates. Both
// channels idle at random. The result side also holds off for a long spell
// while requests keep coming, and the sender pauses until all returns are in.
// ----------------------------------------------------------------------------
module business_day_date_adder_core_tb;
  import bdda_pkg::*;

  localparam int DAY_BITS     = 12;
  localparam int HOLD_CYCLES  = 600;
  localparam int RANDOM_ITEMS = 80;

  typedef struct {
    logic [YEAR_W-1:0]    year;
    logic [MONTH_W-1:0]   month;
    logic [DAY_W-1:0]     day;
    logic [VACDAYS_W-1:0] days;
    int                   gap;
    bit                   drain;
  } date_req_t;

  typedef struct {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [WDAY_W-1:0]  wday;
    logic               invalid;
  } return_date_t;

  logic clk;
  logic rst;

  bdda_in_if  req_ch ();
  bdda_out_if ret_ch ();

  date_req_t    req_q [$];
  return_date_t due_q [$];
  int           idle_cnt;
  int           rdy_wait;
  int           returns_seen;
  logic         hold_off;
  bit           no_gap;
  bit           failed;

  business_day_date_adder_core #(.DAY_COUNT_WIDTH(DAY_BITS)) dut (
    .clk  (clk),
    .rst  (rst),
    .din  (req_ch),
    .dout (ret_ch)
  );

  function automatic int unsigned month_days(int unsigned y, int unsigned m);
    if (m < JANUARY || m > DECEMBER) begin
      return 0;
    end
    if (m == FEBRUARY) begin
      return (((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0) ? 29 : 28;
    end
    return MONTH_LEN[m - 1];
  endfunction

  function automatic bit is_weekend(int unsigned wd);
    return wd == SUNDAY || wd == SATURDAY;
  endfunction

  function automatic return_date_t add_business_days(logic [YEAR_W-1:0] y_in,
                                                     logic [MONTH_W-1:0] m_in,
                                                     logic [DAY_W-1:0] d_in,
                                                     logic [VACDAYS_W-1:0] n_in);
    int unsigned  y, m, d, wd, a, yy, mm, n, passed;
    return_date_t r;
    y = y_in;
    m = m_in;
    d = d_in;
    n = n_in & ((1 << DAY_BITS) - 1);
    passed = 0;
    if (m < JANUARY || m > DECEMBER || d < 1 || d > month_days(y, m)) begin
      r = '{y_in, m_in, d_in, '0, 1'b1};
      return r;
    end
    // year shifted by 400 keeps the congruence positive
    a  = (14 - m) / 12;
    yy = y + 400 - a;
    mm = m + 12 * a - 2;
    wd = (d + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mm) / 12) % 7;
    // leading weekend, counted weekdays, trailing weekend
    while (passed < n || is_weekend(wd)) begin
      if (!is_weekend(wd)) begin
        passed++;
      end
      if (d >= month_days(y, m)) begin
        d = 1;
        if (m == DECEMBER) begin
          m = JANUARY;
          y = (y + 1) % (1 << YEAR_W);
        end else begin
          m++;
        end
      end else begin
        d++;
      end
      wd = (wd + 1) % 7;
    end
    r = '{YEAR_W'(y), MONTH_W'(m), DAY_W'(d), WDAY_W'(wd), 1'b0};
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failed = 1'b1;
    end
  endfunction

  function automatic void queue_date(int unsigned y, int unsigned m, int unsigned d,
                                     int unsigned n);
    date_req_t rq;
    rq.year  = YEAR_W'(y);
    rq.month = MONTH_W'(m);
    rq.day   = DAY_W'(d);
    rq.days  = VACDAYS_W'(n);
    rq.gap   = no_gap ? 0 : $urandom_range(0, 3);
    rq.drain = 1'b0;
    req_q.push_back(rq);
  endfunction

  function automatic void queue_drain();
    date_req_t rq;
    rq = '{'0, '0, '0, '0, 0, 1'b1};
    req_q.push_back(rq);
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst                  = 1'b1;
    req_ch.valid         = 1'b0;
    req_ch.start_year    = '0;
    req_ch.start_month   = '0;
    req_ch.start_day     = '0;
    req_ch.vacation_days = '0;
    ret_ch.ready         = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  // request items
  initial begin
    int unsigned y, m, n, pick;
    no_gap = 1'b0;
    queue_date(2024, 3, 15, 1);
    queue_date(2023, 12, 29, 1);
    queue_date(2024, 2, 28, 1);
    queue_date(2024, 6, 1, 0);
    queue_date(2024, 6, 2, 0);
    queue_date(2024, 6, 3, 0);
    queue_date(0, 0, 0, 0);
    queue_date(16383, 15, 31, 4095);
    queue_date(2023, 2, 29, 3);
    queue_date(2024, 2, 30, 3);
    queue_date(2024, 4, 31, 3);
    queue_date(2024, 13, 1, 3);
    queue_date(1900, 2, 29, 2);
    queue_date(2000, 2, 29, 2);
    queue_date(0, 2, 29, 10);
    queue_date(16383, 12, 31, 5);
    queue_date(1583, 1, 1, 20);
    queue_date(9999, 12, 31, 30);
    queue_date(2024, 1, 31, 22);
    queue_date(1583, 1, 1, 4095);
    queue_date(16383, 1, 1, 4095);
    queue_date(16380, 6, 15, 4095);
    queue_drain();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      no_gap = (i >= 30 && i < 50);
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        queue_date($urandom_range(0, 16383), $urandom_range(0, 15),
                   $urandom_range(0, 31), $urandom_range(0, 4095));
      end else begin
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          y = $urandom_range(16370, 16383);
        end else if (pick == 1) begin
          y = $urandom_range(0, 1582);
        end else begin
          y = $urandom_range(1583, 9999);
        end
        m = $urandom_range(1, 12);
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          n = $urandom_range(0, 40);
        end else if (pick < 9) begin
          n = $urandom_range(0, 4095);
        end else begin
          n = $urandom_range(4000, 4095);
        end
        queue_date(y, m, $urandom_range(1, month_days(y, m)), n);
      end
      if (i == RANDOM_ITEMS / 2) begin
        queue_drain();
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      idle_cnt = 0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (req_ch.valid) begin
        due_q.push_back(add_business_days(req_ch.start_year, req_ch.start_month,
                                          req_ch.start_day, req_ch.vacation_days));
      end
      if (req_q.size() > 0 && req_q[0].drain && due_q.size() == 0) begin
        req_q.delete(0);
      end
      if (req_q.size() > 0 && !req_q[0].drain && idle_cnt >= req_q[0].gap) begin
        req_ch.valid         <= 1'b1;
        req_ch.start_year    <= req_q[0].year;
        req_ch.start_month   <= req_q[0].month;
        req_ch.start_day     <= req_q[0].day;
        req_ch.vacation_days <= req_q[0].days;
        req_q.delete(0);
        idle_cnt = 0;
      end else begin
        req_ch.valid <= 1'b0;
        if (req_q.size() > 0 && !req_q[0].drain) begin
          idle_cnt++;
        end
      end
    end
  end

  // long result hold-off so the block fills and stalls requests
  initial begin
    hold_off <= 1'b0;
    @(posedge clk);
    while (rst || returns_seen < 4) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    return_date_t want;
    if (rst) begin
      ret_ch.ready <= 1'b0;
      returns_seen <= 0;
      rdy_wait = 0;
    end else begin
      if (ret_ch.valid && ret_ch.ready) begin
        returns_seen <= returns_seen + 1;
        if (due_q.size() == 0) begin
          $error("return item with no request outstanding");
          failed = 1'b1;
        end else begin
          want = due_q.pop_front();
          check_field("return_year", want.year, ret_ch.return_year);
          check_field("return_month", want.month, ret_ch.return_month);
          check_field("return_day", want.day, ret_ch.return_day);
          check_field("return_weekday", want.wday, ret_ch.return_weekday);
          check_field("date_invalid", want.invalid, ret_ch.date_invalid);
        end
        rdy_wait = (returns_seen >= 50 && returns_seen < 70) ? 0 : $urandom_range(0, 3);
      end else if (rdy_wait > 0) begin
        rdy_wait--;
      end
      ret_ch.ready <= (rdy_wait == 0) && !hold_off;
    end
  end

  initial begin
    @(negedge clk);
    while (rst || req_q.size() != 0 || req_ch.valid || due_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (failed) begin
      $display("*** FAILED ***");
    end else begin
      $display("*** PASSED ***");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
